FILE: hw/rtl/tcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

    // Coordinate format and the widths of the exact intermediate values.
    localparam int CW = 32;          // coordinate width
    localparam int RW = CW - 1;      // radius width
    localparam int DW = 2 * CW + 3;  // determinant, and the doubled divisor
    localparam int LW = 2 * CW + 1;  // squared side length
    localparam int PW = 2 * CW + 2;  // product of two differences
    localparam int PH = 2 * CW + 3;  // difference times upper half of a length
    localparam int NW = 3 * CW + 3;  // Cramer numerator
    localparam int VW = 2 * CW + 2;  // squared radius and root remainder
    localparam int QW = CW + 2;      // rounded root before clamping

    // Pipeline depth, input beat to output beat.
    localparam int FRONT_LAT = 5;
    localparam int DIV_LAT   = CW + 2;
    localparam int ROOT_LAT  = CW + 4;
    localparam int LATENCY   = FRONT_LAT + DIV_LAT + 1 + ROOT_LAT + 1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COLLINEAR = 2'd1,
        ST_SAT       = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
    } tcc_in_t;

    typedef struct packed {
        logic signed [CW-1:0] centre_x;
        logic signed [CW-1:0] centre_y;
        logic [RW-1:0]        radius;
        status_t              status;
    } tcc_out_t;

    // Data that rides along with an item until it is needed.
    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic                 col;
    } tcc_side_t;

    typedef struct packed {
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [DW-1:0] det;
        tcc_side_t            side;
    } tcc_front_t;

    typedef struct packed {
        logic [CW-1:0] qx;
        logic [CW-1:0] qy;
        logic          bigx;
        logic          bigy;
        logic          negx;
        logic          negy;
        tcc_side_t     side;
    } tcc_div_t;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic                 sat;
        logic                 big;
        logic                 col;
    } tcc_rside_t;

    typedef struct packed {
        logic [CW-1:0] qx;
        logic [CW-1:0] qy;
        tcc_rside_t    side;
    } tcc_rin_t;

    typedef struct packed {
        logic [QW-1:0] root;
        tcc_rside_t    side;
    } tcc_rout_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tcc_front
    import tcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  tcc_in_t    in_data,
    output logic       out_valid,
    output tcc_front_t out_data
);

    logic [FRONT_LAT-1:0] vld_reg;

    logic signed [CW:0]   dx1_reg, dy1_reg, ex1_reg, ey1_reg;
    logic signed [CW-1:0] ax1_reg, ay1_reg;

    logic signed [PW-1:0] dxey2_reg, dyex2_reg, dxdx2_reg, dydy2_reg, exex2_reg, eyey2_reg;
    logic signed [CW:0]   dx2_reg, dy2_reg, ex2_reg, ey2_reg;
    logic signed [CW-1:0] ax2_reg, ay2_reg;

    logic signed [DW-1:0] det3_reg;
    logic [LW-1:0]        ld3_reg, le3_reg;
    logic signed [CW:0]   dx3_reg, dy3_reg, ex3_reg, ey3_reg;
    logic signed [CW-1:0] ax3_reg, ay3_reg;

    logic signed [PW-1:0] eyl4_reg, dyl4_reg, dxl4_reg, exl4_reg;
    logic signed [PH-1:0] eyh4_reg, dyh4_reg, dxh4_reg, exh4_reg;
    logic signed [DW-1:0] det4_reg;
    logic signed [CW-1:0] ax4_reg, ay4_reg;

    tcc_front_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Offsets of B and C from A.
            dx1_reg <= (CW+1)'(in_data.bx) - (CW+1)'(in_data.ax);
            dy1_reg <= (CW+1)'(in_data.by) - (CW+1)'(in_data.ay);
            ex1_reg <= (CW+1)'(in_data.cx) - (CW+1)'(in_data.ax);
            ey1_reg <= (CW+1)'(in_data.cy) - (CW+1)'(in_data.ay);
            ax1_reg <= in_data.ax;
            ay1_reg <= in_data.ay;

            dxey2_reg <= dx1_reg * ey1_reg;
            dyex2_reg <= dy1_reg * ex1_reg;
            dxdx2_reg <= dx1_reg * dx1_reg;
            dydy2_reg <= dy1_reg * dy1_reg;
            exex2_reg <= ex1_reg * ex1_reg;
            eyey2_reg <= ey1_reg * ey1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            ex2_reg   <= ex1_reg;
            ey2_reg   <= ey1_reg;
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;

            // Squares are never negative and each stays below 2^(2*CW).
            det3_reg <= DW'(dxey2_reg) - DW'(dyex2_reg);
            ld3_reg  <= LW'(dxdx2_reg) + LW'(dydy2_reg);
            le3_reg  <= LW'(exex2_reg) + LW'(eyey2_reg);
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            ex3_reg  <= ex2_reg;
            ey3_reg  <= ey2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;

            // Each length is split in two halves to keep the multipliers narrow.
            eyl4_reg <= ey3_reg * $signed({1'b0, ld3_reg[CW-1:0]});
            eyh4_reg <= ey3_reg * $signed({1'b0, ld3_reg[LW-1:CW]});
            dyl4_reg <= dy3_reg * $signed({1'b0, le3_reg[CW-1:0]});
            dyh4_reg <= dy3_reg * $signed({1'b0, le3_reg[LW-1:CW]});
            dxl4_reg <= dx3_reg * $signed({1'b0, le3_reg[CW-1:0]});
            dxh4_reg <= dx3_reg * $signed({1'b0, le3_reg[LW-1:CW]});
            exl4_reg <= ex3_reg * $signed({1'b0, ld3_reg[CW-1:0]});
            exh4_reg <= ex3_reg * $signed({1'b0, ld3_reg[LW-1:CW]});
            det4_reg <= det3_reg;
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;

            out_reg.nx <= (NW'(eyh4_reg) <<< CW) + NW'(eyl4_reg)
                        - (NW'(dyh4_reg) <<< CW) - NW'(dyl4_reg);
            out_reg.ny <= (NW'(dxh4_reg) <<< CW) + NW'(dxl4_reg)
                        - (NW'(exh4_reg) <<< CW) - NW'(exl4_reg);
            out_reg.det     <= det4_reg;
            out_reg.side.ax <= ax4_reg;
            out_reg.side.ay <= ay4_reg;
            out_reg.side.col <= (det4_reg == '0);
        end
    end

    assign out_valid = vld_reg[FRONT_LAT-1];
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tcc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tcc_div
    import tcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  tcc_front_t in_data,
    output logic       out_valid,
    output tcc_div_t   out_data
);

    // Both quotients share the divisor, so the two lanes run side by side.
    logic [NW-1:0] mag_n [2];
    logic [DW-1:0] mag_d;
    logic [NW-1:0] n1_reg [2];
    logic [DW-1:0] d1_reg;
    logic          neg1_reg [2];
    tcc_side_t     side1_reg;
    logic          vld1_reg;

    logic [DW-1:0] rem_reg  [CW+1][2];
    logic [CW-1:0] low_reg  [CW+1][2];
    logic [CW-1:0] q_reg    [CW+1][2];
    logic          big_reg  [CW+1][2];
    logic          neg_reg  [CW+1][2];
    logic [DW-1:0] d_reg    [CW+1];
    tcc_side_t     side_reg [CW+1];
    logic          vld_reg  [CW+1];

    always_comb
    begin
        mag_n[0] = in_data.nx[NW-1] ? (~in_data.nx + 1'b1) : in_data.nx;
        mag_n[1] = in_data.ny[NW-1] ? (~in_data.ny + 1'b1) : in_data.ny;
        mag_d    = in_data.det[DW-1] ? (~in_data.det + 1'b1) : in_data.det;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg   <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg   <= in_valid;
            vld_reg[0] <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Rounded quotient is floor((|n| + |det|) / (2 |det|)).
            for (int l = 0; l < 2; l++)
            begin
                n1_reg[l] <= mag_n[l] + NW'(mag_d);
            end
            d1_reg      <= {mag_d[DW-2:0], 1'b0};
            neg1_reg[0] <= in_data.nx[NW-1] ^ in_data.det[DW-1];
            neg1_reg[1] <= in_data.ny[NW-1] ^ in_data.det[DW-1];
            side1_reg   <= in_data.side;

            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= n1_reg[l][NW-1:CW];
                low_reg[0][l] <= n1_reg[l][CW-1:0];
                q_reg[0][l]   <= '0;
                big_reg[0][l] <= (n1_reg[l][NW-1:CW] >= d1_reg);
                neg_reg[0][l] <= neg1_reg[l];
            end
            d_reg[0]    <= d1_reg;
            side_reg[0] <= side1_reg;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 1; s <= CW; s++)
    begin : g_step
        logic [DW:0]   trial [2];
        logic [DW:0]   diff  [2];
        logic          take  [2];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[l] = {rem_reg[s-1][l], low_reg[s-1][l][CW-1]};
                diff[l]  = trial[l] - {1'b0, d_reg[s-1]};
                take[l]  = (trial[l] >= {1'b0, d_reg[s-1]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[s][l] <= take[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
                    low_reg[s][l] <= {low_reg[s-1][l][CW-2:0], 1'b0};
                    q_reg[s][l]   <= {q_reg[s-1][l][CW-2:0], take[l]};
                    big_reg[s][l] <= big_reg[s-1][l];
                    neg_reg[s][l] <= neg_reg[s-1][l];
                end
                d_reg[s]    <= d_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid     = vld_reg[CW];
    assign out_data.qx   = q_reg[CW][0];
    assign out_data.qy   = q_reg[CW][1];
    assign out_data.bigx = big_reg[CW][0];
    assign out_data.bigy = big_reg[CW][1];
    assign out_data.negx = neg_reg[CW][0];
    assign out_data.negy = neg_reg[CW][1];
    assign out_data.side = side_reg[CW];

endmodule

`default_nettype wire

FILE: hw/rtl/tcc_root.sv
`timescale 1ns / 1ps
`default_nettype none

module tcc_root
    import tcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  tcc_rin_t  in_data,
    output logic      out_valid,
    output tcc_rout_t out_data
);

    logic [2*CW-1:0] sqx1_reg, sqy1_reg;
    tcc_rside_t      side1_reg;
    logic            vld1_reg;

    // Index 0 holds the squared radius, index s+1 the state after root bit CW-s.
    logic [VW-1:0] rem_reg  [CW+2];
    logic [CW:0]   r_reg    [CW+2];
    tcc_rside_t    side_reg [CW+2];
    logic          vld_reg  [CW+2];

    tcc_rout_t out_reg;
    logic      out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg    <= 1'b0;
            vld_reg[0]  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg    <= in_valid;
            vld_reg[0]  <= vld1_reg;
            out_vld_reg <= vld_reg[CW+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx1_reg  <= in_data.qx * in_data.qx;
            sqy1_reg  <= in_data.qy * in_data.qy;
            side1_reg <= in_data.side;

            rem_reg[0]  <= VW'(sqx1_reg) + VW'(sqy1_reg);
            r_reg[0]    <= '0;
            side_reg[0] <= side1_reg;

            // Round to nearest: step up when v - r^2 exceeds r.
            out_reg.root <= QW'(r_reg[CW+1])
                          + QW'(rem_reg[CW+1] > VW'(r_reg[CW+1]));
            out_reg.side <= side_reg[CW+1];
        end
    end

    for (genvar s = 0; s <= CW; s++)
    begin : g_bit
        localparam int B = CW - s;

        logic [VW-1:0] term;
        logic          take;

        // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B), where r has no bits at or below B.
        always_comb
        begin
            term = (VW'(r_reg[s]) << (B + 1)) | (VW'(1) << (2 * B));
            take = (rem_reg[s] >= term);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= take ? (rem_reg[s] - term) : rem_reg[s];
                r_reg[s+1]    <= take ? (r_reg[s] | ((CW+1)'(1) << B)) : r_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/triangle_circumcircle.sv
`timescale 1ns / 1ps
`default_nettype none

// Circumcircle of a triangle in signed Q16.16 fixed point.
// The pts channel carries one triangle per beat (three points A, B, C); the
// circ channel returns the circumcentre, the circumradius and a status code
// per beat: ST_OK, ST_COLLINEAR (centre and radius zero) or ST_SAT (a centre
// coordinate or the radius was clamped to the end of its range).
// The datapath is a single pipeline of 2 * CW + 13 stages from an accepted pts
// beat to its circ beat. Its depth is set by the restoring divider (one
// quotient bit per stage) and the square root (one root bit per stage). A new
// triangle can be accepted in every cycle unless the pipeline is held by
// circ_stall, so the throughput is one triangle per cycle while nothing stalls.
// When circ_stall is high while a result waits, the whole pipeline holds and
// pts_stall goes high in the same cycle; nothing is dropped or repeated.
// Results come back in the order the triangles went in.
// Reset clears all valid bits; the pipeline is empty and ready right away.
module triangle_circumcircle
    import tcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pts_valid,
    output logic     pts_stall,
    input  tcc_in_t  pts,
    output logic     circ_valid,
    input  logic     circ_stall,
    output tcc_out_t circ
);

    typedef struct packed {
        logic signed [CW-1:0] val;
        logic                 sat;
    } place_t;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [RW-1:0]        RMAX = '1;

    function automatic place_t place(logic signed [CW-1:0] a, logic [CW-1:0] q,
                                     logic big, logic neg);
        logic signed [CW:0]   u;
        logic signed [CW+1:0] s;
        place_t               p;
        u = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        s = (CW+2)'(a) + (CW+2)'(u);
        if (big)
        begin
            p.val = neg ? CMIN : CMAX;
            p.sat = 1'b1;
        end
        else if ((s[CW+1] != s[CW]) || (s[CW] != s[CW-1]))
        begin
            p.val = s[CW+1] ? CMIN : CMAX;
            p.sat = 1'b1;
        end
        else
        begin
            p.val = s[CW-1:0];
            p.sat = 1'b0;
        end
        return p;
    endfunction

    logic       en;
    logic       fr_valid, dv_valid, rt_valid;
    tcc_front_t fr_data;
    tcc_div_t   dv_data;
    tcc_rout_t  rt_data;
    place_t     plx, ply;

    tcc_rin_t   pl_reg;
    logic       pl_vld_reg;
    tcc_out_t   out_reg;
    logic       out_vld_reg;

    assign en        = !(out_vld_reg && circ_stall);
    assign pts_stall = !en;

    tcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pts_valid),
        .in_data   (pts),
        .out_valid (fr_valid),
        .out_data  (fr_data)
    );

    tcc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_data   (fr_data),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    always_comb
    begin
        plx = place(dv_data.side.ax, dv_data.qx, dv_data.bigx, dv_data.negx);
        ply = place(dv_data.side.ay, dv_data.qy, dv_data.bigy, dv_data.negy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pl_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            pl_vld_reg  <= dv_valid;
            out_vld_reg <= rt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg.qx       <= dv_data.qx;
            pl_reg.qy       <= dv_data.qy;
            pl_reg.side.cx  <= plx.val;
            pl_reg.side.cy  <= ply.val;
            pl_reg.side.sat <= plx.sat || ply.sat;
            pl_reg.side.big <= dv_data.bigx || dv_data.bigy;
            pl_reg.side.col <= dv_data.side.col;

            if (rt_data.side.col)
            begin
                out_reg.centre_x <= '0;
                out_reg.centre_y <= '0;
                out_reg.radius   <= '0;
                out_reg.status   <= ST_COLLINEAR;
            end
            else if (rt_data.side.big || (rt_data.root > QW'(RMAX)))
            begin
                out_reg.centre_x <= rt_data.side.cx;
                out_reg.centre_y <= rt_data.side.cy;
                out_reg.radius   <= RMAX;
                out_reg.status   <= ST_SAT;
            end
            else
            begin
                out_reg.centre_x <= rt_data.side.cx;
                out_reg.centre_y <= rt_data.side.cy;
                out_reg.radius   <= rt_data.root[RW-1:0];
                out_reg.status   <= rt_data.side.sat ? ST_SAT : ST_OK;
            end
        end
    end

    tcc_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pl_vld_reg),
        .in_data   (pl_reg),
        .out_valid (rt_valid),
        .out_data  (rt_data)
    );

    assign circ_valid = out_vld_reg;
    assign circ       = out_reg;

    a_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        circ_valid && (circ.status == ST_COLLINEAR) |->
            (circ.centre_x == '0) && (circ.centre_y == '0) && (circ.radius == '0))
        else $error("collinear result carries a nonzero centre or radius");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        circ_valid |-> (circ.status == ST_OK) || (circ.status == ST_COLLINEAR)
                       || (circ.status == ST_SAT))
        else $error("status code out of range");

    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !circ_valid |-> !pts_stall)
        else $error("input stalled while the output register is empty");

    a_sat_radius: assert property (@(posedge clk) disable iff (!rst_n)
        circ_valid && (circ.status == ST_OK) |->
            (circ.centre_x != CMAX || circ.centre_y != CMIN || circ.radius != RMAX)
            || !$isunknown(circ.radius))
        else $error("unsaturated result is unknown");

endmodule

`default_nettype wire
